// ===== rtl/lsna_pkg.sv =====
// Package for the lazy subtree node allocator: sizes, codes, port structs and helpers.
package lsna_pkg;

  // Node store size and id widths
  localparam int NODE_COUNT = 64;
  localparam int ID_W       = 6;
  localparam int ID_LIMIT   = (NODE_COUNT < (1 << ID_W)) ? NODE_COUNT : (1 << ID_W);
  localparam int IDX_W      = $clog2(ID_LIMIT);

  // Command codes
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LINK    = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NULL  = 2'd2
  } status_t;

  // Where the current value of one next link lives
  typedef enum logic [1:0] {
    SRC_INIT   = 2'd0,
    SRC_ZERO   = 2'd1,
    SRC_BANK_A = 2'd2,
    SRC_BANK_B = 2'd3
  } next_src_t;

  // The three links of one node
  typedef struct packed {
    logic [ID_W-1:0] left;
    logic [ID_W-1:0] right;
    logic [ID_W-1:0] next;
  } node_links_t;

  // Link store updates for one item, listed in the order they take effect
  typedef struct packed {
    logic             left_we;
    logic [IDX_W-1:0] left_idx;
    logic [ID_W-1:0]  left_val;
    logic             right_we;
    logic [IDX_W-1:0] right_idx;
    logic [ID_W-1:0]  right_val;
    logic             seq_a_we;
    logic [IDX_W-1:0] seq_a_idx;
    logic [ID_W-1:0]  seq_a_val;
    logic             seq_b_we;
    logic [IDX_W-1:0] seq_b_idx;
    logic [ID_W-1:0]  seq_b_val;
    logic             term_we;
    logic [IDX_W-1:0] term_idx;
    logic             clr_we;
    logic [IDX_W-1:0] clr_idx;
  } store_wr_t;

  // Nonzero id below the store size
  function automatic logic id_valid(input logic [ID_W-1:0] id);
    return (id != '0) && ({1'b0, id} < (ID_W+1)'(ID_LIMIT));
  endfunction

  // Next link of an entry after reset: i+1, last entry null
  function automatic logic [ID_W-1:0] init_next(input logic [IDX_W-1:0] idx);
    logic [ID_W-1:0] v;
    v = ID_W'(idx);
    if (idx == IDX_W'(ID_LIMIT - 1)) begin
      return '0;
    end
    return v + ID_W'(1);
  endfunction

endpackage

// ===== rtl/lsna_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lsna_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lsna_store.sv =====
// Link store: left/right/next link RAMs, per-entry valid and source tags, read forwarding.
module lsna_store (
  input  logic                      clk,
  input  logic                      rst,
  input  lsna_pkg::store_wr_t       wr,
  input  logic                      rd_en,
  input  logic [lsna_pkg::IDX_W-1:0] rd_addr,
  output lsna_pkg::node_links_t     rd_links
);
  import lsna_pkg::*;

  // Per-entry state kept in flops
  logic [ID_LIMIT-1:0] left_vld;
  logic [ID_LIMIT-1:0] right_vld;
  next_src_t           next_src [ID_LIMIT];

  // RAM write strobes: only nonzero values need storage
  logic left_ram_we;
  logic right_ram_we;
  logic bank_a_we;
  logic bank_b_we;

  assign left_ram_we  = wr.left_we  && (wr.left_val  != '0);
  assign right_ram_we = wr.right_we && (wr.right_val != '0);
  assign bank_a_we    = wr.seq_a_we && (wr.seq_a_val != '0);
  assign bank_b_we    = wr.seq_b_we && (wr.seq_b_val != '0);

  logic [ID_W-1:0] left_q;
  logic [ID_W-1:0] right_q;
  logic [ID_W-1:0] bank_a_q;
  logic [ID_W-1:0] bank_b_q;

  lsna_ram #(.WIDTH(ID_W), .DEPTH(ID_LIMIT)) u_left_ram (
    .clk   (clk),
    .we    (left_ram_we),
    .waddr (wr.left_idx),
    .wdata (wr.left_val),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (left_q)
  );

  lsna_ram #(.WIDTH(ID_W), .DEPTH(ID_LIMIT)) u_right_ram (
    .clk   (clk),
    .we    (right_ram_we),
    .waddr (wr.right_idx),
    .wdata (wr.right_val),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (right_q)
  );

  lsna_ram #(.WIDTH(ID_W), .DEPTH(ID_LIMIT)) u_next_bank_a (
    .clk   (clk),
    .we    (bank_a_we),
    .waddr (wr.seq_a_idx),
    .wdata (wr.seq_a_val),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (bank_a_q)
  );

  lsna_ram #(.WIDTH(ID_W), .DEPTH(ID_LIMIT)) u_next_bank_b (
    .clk   (clk),
    .we    (bank_b_we),
    .waddr (wr.seq_b_idx),
    .wdata (wr.seq_b_val),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (bank_b_q)
  );

  // Valid bits and next-link source tags, updated in program order
  always_ff @(posedge clk) begin
    if (rst) begin
      left_vld  <= '0;
      right_vld <= '0;
      for (int i = 0; i < ID_LIMIT; i++) begin
        next_src[i] <= SRC_INIT;
      end
    end else begin
      if (wr.left_we) begin
        left_vld[wr.left_idx] <= (wr.left_val != '0);
      end
      if (wr.right_we) begin
        right_vld[wr.right_idx] <= (wr.right_val != '0);
      end
      if (wr.seq_a_we) begin
        next_src[wr.seq_a_idx] <= (wr.seq_a_val != '0) ? SRC_BANK_A : SRC_ZERO;
      end
      if (wr.seq_b_we) begin
        next_src[wr.seq_b_idx] <= (wr.seq_b_val != '0) ? SRC_BANK_B : SRC_ZERO;
      end
      if (wr.term_we) begin
        next_src[wr.term_idx] <= SRC_ZERO;
      end
      if (wr.clr_we) begin
        left_vld[wr.clr_idx]  <= 1'b0;
        right_vld[wr.clr_idx] <= 1'b0;
        next_src[wr.clr_idx]  <= SRC_ZERO;
      end
    end
  end

  // Forward RAM writes that land on the edge of the read
  logic             rd_fwd_left;
  logic             rd_fwd_right;
  logic             rd_fwd_a;
  logic             rd_fwd_b;
  logic [ID_W-1:0]  fwd_left_val;
  logic [ID_W-1:0]  fwd_right_val;
  logic [ID_W-1:0]  fwd_a_val;
  logic [ID_W-1:0]  fwd_b_val;
  logic [IDX_W-1:0] rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_fwd_left  <= 1'b0;
      rd_fwd_right <= 1'b0;
      rd_fwd_a     <= 1'b0;
      rd_fwd_b     <= 1'b0;
    end else if (rd_en) begin
      rd_fwd_left  <= left_ram_we  && (wr.left_idx  == rd_addr);
      rd_fwd_right <= right_ram_we && (wr.right_idx == rd_addr);
      rd_fwd_a     <= bank_a_we    && (wr.seq_a_idx == rd_addr);
      rd_fwd_b     <= bank_b_we    && (wr.seq_b_idx == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_left_val  <= wr.left_val;
      fwd_right_val <= wr.right_val;
      fwd_a_val     <= wr.seq_a_val;
      fwd_b_val     <= wr.seq_b_val;
      rd_idx        <= rd_addr;
    end
  end

  // Decode the links of the entry last read
  logic [ID_W-1:0] left_data;
  logic [ID_W-1:0] right_data;
  logic [ID_W-1:0] bank_a_data;
  logic [ID_W-1:0] bank_b_data;

  assign left_data   = rd_fwd_left  ? fwd_left_val  : left_q;
  assign right_data  = rd_fwd_right ? fwd_right_val : right_q;
  assign bank_a_data = rd_fwd_a     ? fwd_a_val     : bank_a_q;
  assign bank_b_data = rd_fwd_b     ? fwd_b_val     : bank_b_q;

  always_comb begin
    rd_links.left  = left_vld[rd_idx]  ? left_data  : '0;
    rd_links.right = right_vld[rd_idx] ? right_data : '0;
    case (next_src[rd_idx])
      SRC_INIT:   rd_links.next = init_next(rd_idx);
      SRC_ZERO:   rd_links.next = '0;
      SRC_BANK_A: rd_links.next = bank_a_data;
      SRC_BANK_B: rd_links.next = bank_b_data;
      default:    rd_links.next = '0;
    endcase
  end

endmodule

// ===== rtl/lsna_exec.sv =====
// Command logic: allocate with splice, release, link; builds store updates and result.
module lsna_exec (
  input  logic                       go,
  input  logic [1:0]                 cmd,
  input  logic [lsna_pkg::ID_W-1:0]  node_id,
  input  logic                       side,
  input  logic [lsna_pkg::ID_W-1:0]  child_id,
  input  logic [lsna_pkg::ID_W-1:0]  free_head,
  input  lsna_pkg::node_links_t      head_links,
  output lsna_pkg::store_wr_t        wr,
  output logic                       head_we,
  output logic [lsna_pkg::ID_W-1:0]  head_new,
  output logic [lsna_pkg::ID_W-1:0]  granted_id,
  output logic [1:0]                 status
);
  import lsna_pkg::*;

  store_wr_t       upd;
  logic [ID_W-1:0] w [3];
  logic            is_child [3];
  logic [1:0]      n;
  logic [1:0]      last;
  logic [ID_W-1:0] child_val;
  status_t         st;

  always_comb begin
    upd        = '0;
    head_we    = 1'b0;
    head_new   = '0;
    granted_id = '0;
    st         = ST_OK;
    n          = '0;
    last       = '0;
    child_val  = '0;
    for (int k = 0; k < 3; k++) begin
      w[k]        = '0;
      is_child[k] = 1'b0;
    end

    case (cmd)
      CMD_ALLOC: begin
        if (!id_valid(free_head)) begin
          st = ST_EMPTY;
        end else begin
          // Gather the non-null links of the popped node: left, right, next
          if (head_links.left != '0) begin
            w[n] = head_links.left;
            is_child[n] = 1'b1;
            n = n + 2'd1;
          end
          if (head_links.right != '0) begin
            w[n] = head_links.right;
            is_child[n] = 1'b1;
            n = n + 2'd1;
          end
          if (head_links.next != '0) begin
            w[n] = head_links.next;
            is_child[n] = 1'b0;
            n = n + 2'd1;
          end
          last = n - 2'd1;

          // Chain them into the free list
          head_we  = 1'b1;
          head_new = (n == 2'd0) ? '0 : w[0];
          upd.seq_a_we  = (n >= 2'd2);
          upd.seq_a_idx = w[0][IDX_W-1:0];
          upd.seq_a_val = w[1];
          upd.seq_b_we  = (n == 2'd3);
          upd.seq_b_idx = w[1][IDX_W-1:0];
          upd.seq_b_val = w[2];
          upd.term_we   = (n != 2'd0) && is_child[last];
          upd.term_idx  = w[last][IDX_W-1:0];

          // Hand the node out with its links cleared
          upd.clr_we  = 1'b1;
          upd.clr_idx = free_head[IDX_W-1:0];
          granted_id  = free_head;
        end
      end
      CMD_RELEASE: begin
        if (!id_valid(node_id)) begin
          st = ST_NULL;
        end else begin
          upd.seq_a_we  = 1'b1;
          upd.seq_a_idx = node_id[IDX_W-1:0];
          upd.seq_a_val = free_head;
          head_we       = 1'b1;
          head_new      = node_id;
        end
      end
      CMD_LINK: begin
        if (!id_valid(node_id)) begin
          st = ST_NULL;
        end else begin
          child_val = id_valid(child_id) ? child_id : '0;
          if (side == 1'b0) begin
            upd.left_we  = 1'b1;
            upd.left_idx = node_id[IDX_W-1:0];
            upd.left_val = child_val;
          end else begin
            upd.right_we  = 1'b1;
            upd.right_idx = node_id[IDX_W-1:0];
            upd.right_val = child_val;
          end
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase

    // Updates only take effect when the item is processed
    upd.left_we  = upd.left_we  && go;
    upd.right_we = upd.right_we && go;
    upd.seq_a_we = upd.seq_a_we && go;
    upd.seq_b_we = upd.seq_b_we && go;
    upd.term_we  = upd.term_we  && go;
    upd.clr_we   = upd.clr_we   && go;
    head_we      = head_we      && go;
  end

  assign wr     = upd;
  assign status = st;

endmodule

// ===== rtl/lazy_subtree_node_allocator.sv =====
// Top level of the lazy subtree node allocator: input register, head register, result register.
// An accepted item waits in the input register until its result can enter the result register.
// Throughput: one item per cycle for every command while rsp is not stalled; the link RAMs are
//   read at the edge an item is accepted, with writes of the item ahead forwarded into that read.
// Reset: synchronous; the free list holds every nonzero node right after reset, with no clearing pass
//   (per-entry valid bits and next-link tags in flops stand in for the reset contents).
module lazy_subtree_node_allocator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [1:0]                cmd,
  input  logic [lsna_pkg::ID_W-1:0] node_id,
  input  logic                      side,
  input  logic [lsna_pkg::ID_W-1:0] child_id,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic [lsna_pkg::ID_W-1:0] granted_id,
  output logic [1:0]                status
);
  import lsna_pkg::*;

  // Input register
  logic            in_vld;
  logic [1:0]      in_cmd;
  logic [ID_W-1:0] in_node;
  logic            in_side;
  logic [ID_W-1:0] in_child;

  // Free list head
  logic [ID_W-1:0] free_head;
  logic [ID_W-1:0] free_head_next;

  logic fire;
  logic accept;

  // Process when the result register is free or drains this cycle
  assign fire      = in_vld && (!rsp_valid || !rsp_stall);
  assign req_stall = in_vld && !fire;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd   <= cmd;
      in_node  <= node_id;
      in_side  <= side;
      in_child <= child_id;
    end
  end

  // Command logic and link store
  store_wr_t       wr;
  node_links_t     head_links;
  logic            head_we;
  logic [ID_W-1:0] head_new;
  logic [ID_W-1:0] res_granted;
  logic [1:0]      res_status;

  lsna_exec u_exec (
    .go         (fire),
    .cmd        (in_cmd),
    .node_id    (in_node),
    .side       (in_side),
    .child_id   (in_child),
    .free_head  (free_head),
    .head_links (head_links),
    .wr         (wr),
    .head_we    (head_we),
    .head_new   (head_new),
    .granted_id (res_granted),
    .status     (res_status)
  );

  assign free_head_next = head_we ? head_new : free_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= ID_W'(1);
    end else begin
      free_head <= free_head_next;
    end
  end

  // Links of the head the accepted item will see
  lsna_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_en    (accept),
    .rd_addr  (free_head_next[IDX_W-1:0]),
    .rd_links (head_links)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      granted_id <= res_granted;
      status     <= res_status;
    end
  end

endmodule
